// File: src/shbe_pkg.sv
package shbe_pkg;

  localparam int LENGTH_BITS_DEF = 20;
  localparam int MAX_CODE_BITS   = 32;
  localparam int LEAF_COUNT      = 256;
  localparam int NODE_LIMIT      = 511;
  localparam int NODE_W          = 9;
  localparam int WEIGHT_W        = 17;
  localparam int CLEN_W          = 6;

  localparam logic FUNC_COUNT  = 1'b0;
  localparam logic FUNC_ENCODE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_SINGLE    = 3'd2,
    ST_CODE_LONG = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_ORDER     = 3'd5
  } status_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    status_t     status;
  } out_t;

endpackage

// File: src/static_huffman_block_encoder.sv
// counting byte: histogram read, then update; encoding byte: code read, reversal, bit
// buffer add, output, one more output when a full word and the final flush both leave,
// plus output stalls. block end: scaling runs an 8-step divider per symbol, each pick
// scans the node memory at one entry per cycle (up to 255 merges x 2 picks), code
// assignment writes both children of each internal node, header packs bytes into 33
// words. one item in flight at a time; src_stall is high until its results are queued.
// rst is synchronous: control, histogram valid bits and bit buffer clear, no clearing pass.
module static_huffman_block_encoder #(
  parameter int LENGTH_BITS = shbe_pkg::LENGTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_stall,
  input  shbe_pkg::in_t   src_item,
  output logic            dst_valid,
  input  logic            dst_stall,
  output shbe_pkg::out_t  dst_item
);

  localparam int NUM_W  = LENGTH_BITS + 9;
  localparam int NW     = shbe_pkg::NODE_W;
  localparam int WW     = shbe_pkg::WEIGHT_W;
  localparam int CW     = shbe_pkg::CLEN_W;
  localparam int CB     = shbe_pkg::MAX_CODE_BITS;
  localparam logic [LENGTH_BITS-1:0] MAX_LEN = {LENGTH_BITS{1'b1}};
  localparam logic [NW-1:0] LEAVES   = NW'(shbe_pkg::LEAF_COUNT);
  localparam logic [NW-1:0] NODE_MAX = NW'(shbe_pkg::NODE_LIMIT);
  localparam logic [CW-1:0] LEN_SAT  = CW'(CB + 1);

  typedef enum logic [20:0] {
    S_IDLE      = 21'd1 << 0,
    S_HIST_UPD  = 21'd1 << 1,
    S_RESULT    = 21'd1 << 2,
    S_SC_RD     = 21'd1 << 3,
    S_SC_LD     = 21'd1 << 4,
    S_SC_DIV    = 21'd1 << 5,
    S_SC_WR     = 21'd1 << 6,
    S_SCAN      = 21'd1 << 7,
    S_PICK_DONE = 21'd1 << 8,
    S_MERGE_WR  = 21'd1 << 9,
    S_ASG_INIT  = 21'd1 << 10,
    S_ASG_RD    = 21'd1 << 11,
    S_ASG_W0    = 21'd1 << 12,
    S_ASG_W1    = 21'd1 << 13,
    S_ASG_CHECK = 21'd1 << 14,
    S_HDR_RD    = 21'd1 << 15,
    S_HDR_PUT   = 21'd1 << 16,
    S_HDR_PUSH  = 21'd1 << 17,
    S_ENC_REV   = 21'd1 << 18,
    S_ENC_ADD   = 21'd1 << 19,
    S_ENC_OUT   = 21'd1 << 20
  } state_t;

  function automatic logic [CB-1:0] rev_code(input logic [CB-1:0] v);
    logic [CB-1:0] r;
    for (int k = 0; k < CB; k++) r[k] = v[CB-1-k];
    return r;
  endfunction

  state_t state;

  // memories
  logic [LENGTH_BITS-1:0] hist_mem [shbe_pkg::LEAF_COUNT];
  logic [LENGTH_BITS-1:0] hist_rd;
  logic                   hist_valid_rd;
  logic [7:0]             hist_raddr;
  logic [WW:0]            nw_mem [shbe_pkg::NODE_LIMIT];   // {taken, weight}
  logic [WW:0]            nw_rd, nw_wdata;
  logic [NW-1:0]          nw_raddr, nw_waddr;
  logic                   nw_we;
  logic [2*NW-1:0]        nch_mem [shbe_pkg::NODE_LIMIT];
  logic [2*NW-1:0]        nch_rd;
  logic [CB+CW-1:0]       ncode_mem [shbe_pkg::NODE_LIMIT]; // {code, length}
  logic [CB+CW-1:0]       ncode_rd, ncode_wdata;
  logic [NW-1:0]          ncode_raddr, ncode_waddr;
  logic                   ncode_we;

  // block state
  logic [shbe_pkg::LEAF_COUNT-1:0] hist_valid;
  logic [LENGTH_BITS-1:0] block_length, peak;
  logic                   phase;
  logic [127:0]           bit_buf;
  logic [6:0]             bit_fill;

  // per-item and build registers
  logic [7:0]       item_sym;
  logic             item_last;
  logic [7:0]       sweep;
  logic [NUM_W-1:0] rem, dvs;
  logic [7:0]       quo;
  logic [2:0]       step;
  logic [NW-1:0]    nt, si, chk_idx, found, pa, n;
  logic             chk_v, found_v, pick_b, asg_err;
  logic [WW-1:0]    best, wa;
  logic [63:0]      hdr_word;
  logic [2:0]       hdr_cnt;
  logic [3:0]       hdr_nb;
  logic             hdr_last;
  logic [CB-1:0]    enc_bits;
  logic [CW-1:0]    enc_len;
  shbe_pkg::status_t res_status;

  // combinational
  logic                   out_free, accept, push, do_clear, set_phase, single_err;
  shbe_pkg::out_t         push_item;
  logic [LENGTH_BITS-1:0] hist_cur, cnt_inc;
  logic [CW-1:0]          len_inc, enc_l;
  logic [NW-1:0]          child;
  logic                   full_word;

  assign out_free  = !dst_valid || !dst_stall;
  assign src_stall = (state != S_IDLE);
  assign accept    = src_valid && !src_stall;
  assign hist_cur  = hist_valid_rd ? hist_rd : '0;
  assign cnt_inc   = hist_cur + 1'b1;
  assign len_inc   = (ncode_rd[CW-1:0] >= LEN_SAT) ? LEN_SAT : ncode_rd[CW-1:0] + 1'b1;
  assign child     = (state == S_ASG_W0) ? nch_rd[2*NW-1:NW] : nch_rd[NW-1:0];
  assign enc_l     = (ncode_rd[CW-1:0] > CW'(CB)) ? CW'(CB) : ncode_rd[CW-1:0];
  assign full_word = (bit_fill >= 7'd64);
  assign single_err = !found_v && pick_b && (pa != nt - 1'b1);

  assign hist_raddr  = (state == S_IDLE) ? src_item.data_byte : sweep;
  assign nw_raddr    = (state == S_SCAN) ? si : {1'b0, sweep};
  assign ncode_raddr = (state == S_IDLE) ? {1'b0, src_item.data_byte} : n;

  always_comb begin
    nw_we    = 1'b0;
    nw_waddr = {1'b0, sweep};
    nw_wdata = '0;
    ncode_we    = 1'b0;
    ncode_waddr = {1'b0, sweep};
    ncode_wdata = '0;
    case (state)
      S_SC_WR: begin
        nw_we    = 1'b1;
        nw_wdata = {1'b0, WW'(quo)};
        ncode_we = 1'b1;
      end
      S_PICK_DONE: begin
        nw_we    = found_v;
        nw_waddr = found;
        nw_wdata = {1'b1, best};
      end
      S_MERGE_WR: begin
        nw_we    = 1'b1;
        nw_waddr = nt;
        nw_wdata = {1'b0, WW'(wa + best)};
      end
      S_ASG_INIT: begin
        ncode_we    = 1'b1;
        ncode_waddr = nt - 1'b1;
      end
      S_ASG_W0, S_ASG_W1: begin
        ncode_we    = 1'b1;
        ncode_waddr = child;
        ncode_wdata = {ncode_rd[CB+CW-2:CW], (state == S_ASG_W1), len_inc};
      end
      default: ;
    endcase
  end

  always_comb begin
    push      = 1'b0;
    push_item = '0;
    do_clear  = 1'b0;
    set_phase = 1'b0;
    case (state)
      S_IDLE:
        if (accept && src_item.func == phase && phase == shbe_pkg::FUNC_COUNT &&
            block_length == MAX_LEN) do_clear = 1'b1;
      S_SC_RD:     if (peak == '0) do_clear = 1'b1;
      S_PICK_DONE: if (single_err) do_clear = 1'b1;
      S_ASG_CHECK: if (asg_err) do_clear = 1'b1;
      S_RESULT: begin
        push = out_free;
        push_item.last_word = 1'b1;
        push_item.status    = res_status;
      end
      S_HDR_PUSH: begin
        push = out_free;
        push_item.out_word    = hdr_word;
        push_item.valid_bytes = hdr_nb;
        push_item.last_word   = hdr_last;
        push_item.status      = shbe_pkg::ST_OK;
        do_clear  = out_free && hdr_last;
        set_phase = 1'b1;
      end
      S_ENC_OUT: begin
        push_item.out_word = bit_buf[63:0];
        push_item.status   = shbe_pkg::ST_OK;
        if (full_word) begin
          push = out_free;
          push_item.valid_bytes = 4'd8;
          push_item.last_word   = item_last && (bit_fill == 7'd64);
          do_clear = out_free && item_last && (bit_fill == 7'd64);
        end else if (item_last) begin
          push = out_free;
          push_item.valid_bytes = 4'((bit_fill + 7'd7) >> 3);
          push_item.last_word   = 1'b1;
          do_clear = out_free;
        end
      end
      default: ;
    endcase
  end

  // memories: synchronous read, one write port each
  always_ff @(posedge clk) begin
    hist_rd       <= hist_mem[hist_raddr];
    hist_valid_rd <= hist_valid[hist_raddr];
    if (state == S_HIST_UPD) hist_mem[item_sym] <= cnt_inc;
  end

  always_ff @(posedge clk) begin
    nw_rd <= nw_mem[nw_raddr];
    if (nw_we) nw_mem[nw_waddr] <= nw_wdata;
  end

  always_ff @(posedge clk) begin
    nch_rd <= nch_mem[n];
    if (state == S_MERGE_WR) nch_mem[nt] <= {pa, found};
  end

  always_ff @(posedge clk) begin
    ncode_rd <= ncode_mem[ncode_raddr];
    if (ncode_we) ncode_mem[ncode_waddr] <= ncode_wdata;
  end

  // block-level state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid   <= '0;
      block_length <= '0;
      peak         <= '0;
      phase        <= shbe_pkg::FUNC_COUNT;
      bit_buf      <= '0;
      bit_fill     <= '0;
    end else if (do_clear) begin
      hist_valid   <= '0;
      block_length <= '0;
      peak         <= '0;
      phase        <= set_phase;
      bit_buf      <= '0;
      bit_fill     <= '0;
    end else begin
      if (state == S_HIST_UPD) begin
        hist_valid[item_sym] <= 1'b1;
        block_length <= block_length + 1'b1;
        if (cnt_inc > peak) peak <= cnt_inc;
      end
      if (state == S_ENC_ADD) begin
        bit_buf  <= bit_buf | (128'(enc_bits) << bit_fill);
        bit_fill <= bit_fill + 7'(enc_len);
      end
      if (state == S_ENC_OUT && push && full_word) begin
        bit_buf  <= {64'd0, bit_buf[127:64]};
        bit_fill <= bit_fill - 7'd64;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nt    <= LEAVES;
    end else begin
      case (state)
        S_IDLE: if (accept) begin
          item_sym  <= src_item.data_byte;
          item_last <= src_item.last;
          if (src_item.func != phase) begin
            res_status <= shbe_pkg::ST_ORDER;
            state      <= S_RESULT;
          end else if (phase == shbe_pkg::FUNC_COUNT) begin
            if (block_length == MAX_LEN) begin
              res_status <= shbe_pkg::ST_TOO_LONG;
              state      <= S_RESULT;
            end else begin
              state <= S_HIST_UPD;
            end
          end else begin
            state <= S_ENC_REV;
          end
        end
        S_HIST_UPD: begin
          sweep <= '0;
          state <= item_last ? S_SC_RD : S_IDLE;
        end
        S_RESULT: if (out_free) state <= S_IDLE;
        S_SC_RD: begin
          if (peak == '0) begin
            res_status <= shbe_pkg::ST_EMPTY;
            state      <= S_RESULT;
          end else begin
            state <= S_SC_LD;
          end
        end
        S_SC_LD: begin
          // ceil(count * 255 / peak), quotient fits in 8 bits
          rem   <= NUM_W'({hist_cur, 8'd0}) - NUM_W'(hist_cur) + NUM_W'(peak) - NUM_W'(1);
          dvs   <= NUM_W'({peak, 7'd0});
          quo   <= '0;
          step  <= '0;
          state <= S_SC_DIV;
        end
        S_SC_DIV: begin
          if (rem >= dvs) rem <= rem - dvs;
          quo  <= {quo[6:0], (rem >= dvs)};
          dvs  <= dvs >> 1;
          step <= step + 1'b1;
          if (step == 3'd7) state <= S_SC_WR;
        end
        S_SC_WR: begin
          sweep <= sweep + 1'b1;
          if (sweep == 8'hff) begin
            nt      <= LEAVES;
            si      <= '0;
            chk_v   <= 1'b0;
            found_v <= 1'b0;
            pick_b  <= 1'b0;
            state   <= S_SCAN;
          end else begin
            state <= S_SC_RD;
          end
        end
        S_SCAN: begin
          // lowest index wins ties: strict compare
          if (chk_v && !nw_rd[WW] && nw_rd[WW-1:0] != '0 &&
              (!found_v || nw_rd[WW-1:0] < best)) begin
            best    <= nw_rd[WW-1:0];
            found   <= chk_idx;
            found_v <= 1'b1;
          end
          if (si != nt) begin
            si      <= si + 1'b1;
            chk_idx <= si;
            chk_v   <= 1'b1;
          end else begin
            chk_v <= 1'b0;
            if (!chk_v) state <= S_PICK_DONE;
          end
        end
        S_PICK_DONE: begin
          if (!found_v) begin
            if (single_err) begin
              res_status <= shbe_pkg::ST_SINGLE;
              state      <= S_RESULT;
            end else begin
              state <= S_ASG_INIT;
            end
          end else if (!pick_b) begin
            pa      <= found;
            wa      <= best;
            pick_b  <= 1'b1;
            si      <= '0;
            chk_v   <= 1'b0;
            found_v <= 1'b0;
            state   <= S_SCAN;
          end else begin
            state <= S_MERGE_WR;
          end
        end
        S_MERGE_WR: begin
          nt <= nt + 1'b1;
          if (nt + 1'b1 == NODE_MAX) begin
            state <= S_ASG_INIT;
          end else begin
            pick_b  <= 1'b0;
            si      <= '0;
            chk_v   <= 1'b0;
            found_v <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_ASG_INIT: begin
          n       <= nt - 1'b1;
          asg_err <= 1'b0;
          state   <= (nt > LEAVES) ? S_ASG_RD : S_ASG_CHECK;
        end
        S_ASG_RD: state <= S_ASG_W0;
        S_ASG_W0: begin
          if (child < LEAVES && len_inc > CW'(CB)) asg_err <= 1'b1;
          state <= S_ASG_W1;
        end
        S_ASG_W1: begin
          if (child < LEAVES && len_inc > CW'(CB)) asg_err <= 1'b1;
          if (n == LEAVES) begin
            state <= S_ASG_CHECK;
          end else begin
            n     <= n - 1'b1;
            state <= S_ASG_RD;
          end
        end
        S_ASG_CHECK: begin
          if (asg_err) begin
            res_status <= shbe_pkg::ST_CODE_LONG;
            state      <= S_RESULT;
          end else begin
            hdr_word <= {32'd0, 32'(block_length)};
            hdr_cnt  <= 3'd4;
            sweep    <= '0;
            state    <= S_HDR_RD;
          end
        end
        S_HDR_RD: state <= S_HDR_PUT;
        S_HDR_PUT: begin
          hdr_word[{hdr_cnt, 3'b000} +: 8] <= nw_rd[7:0];
          hdr_cnt <= hdr_cnt + 1'b1;
          sweep   <= sweep + 1'b1;
          if (hdr_cnt == 3'd7) begin
            hdr_nb   <= 4'd8;
            hdr_last <= 1'b0;
            state    <= S_HDR_PUSH;
          end else if (sweep == 8'hff) begin
            hdr_nb   <= 4'(hdr_cnt) + 4'd1;
            hdr_last <= 1'b1;
            state    <= S_HDR_PUSH;
          end else begin
            state <= S_HDR_RD;
          end
        end
        S_HDR_PUSH: if (out_free) begin
          hdr_word <= '0;
          hdr_cnt  <= '0;
          state    <= hdr_last ? S_IDLE : S_HDR_RD;
        end
        S_ENC_REV: begin
          // msb-first code into an lsb-first stream
          enc_bits <= rev_code(ncode_rd[CB+CW-1:CW]) >> (CW'(CB) - enc_l);
          enc_len  <= enc_l;
          state    <= S_ENC_ADD;
        end
        S_ENC_ADD: state <= S_ENC_OUT;
        S_ENC_OUT: begin
          if (full_word) begin
            if (out_free && (!item_last || bit_fill == 7'd64)) state <= S_IDLE;
          end else if (item_last) begin
            if (out_free) state <= S_IDLE;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (push) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) dst_item <= push_item;
  end

  a_err_status_only: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.status != shbe_pkg::ST_OK |->
      dst_item.valid_bytes == 4'd0 && dst_item.last_word)
    else $error("error result carries data");

  a_fill_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> bit_fill < 7'd64)
    else $error("full word left in bit buffer");

  a_order_result: assert property (@(posedge clk) disable iff (rst)
    accept && src_item.func != phase |=> state == S_RESULT && res_status == shbe_pkg::ST_ORDER)
    else $error("wrong pass transaction not reported");

endmodule

// File: dv/tb_static_huffman_block_encoder.sv
`timescale 1ns / 100ps

module tb_static_huffman_block_encoder;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HDR_BYTES   = 260;

  logic clk;
  logic rst;
  logic src_valid;
  logic src_stall;
  shbe_pkg::in_t  src_item;
  logic dst_valid;
  logic dst_stall;
  shbe_pkg::out_t dst_item;

  static_huffman_block_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

  shbe_pkg::in_t  byte_q[$];
  shbe_pkg::out_t word_q[$];
  int   mismatches = 0;
  int   words_seen = 0;
  int   blocks_made = 0;
  int   items_made = 0;
  int   cycles = 0;

  // predictor state
  int unsigned     hist[shbe_pkg::LEAF_COUNT];
  int unsigned     weight[shbe_pkg::NODE_LIMIT];
  bit              taken[shbe_pkg::NODE_LIMIT];
  int unsigned     kids[shbe_pkg::NODE_LIMIT][2];
  logic [31:0]     sym_code[shbe_pkg::LEAF_COUNT];
  int unsigned     sym_len[shbe_pkg::LEAF_COUNT];
  int unsigned     blk_len;
  logic [63:0]     bits[2];
  int unsigned     fill;
  bit              phase;
  int unsigned     nodes;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void push_word(logic [63:0] w, int unsigned nb, bit lw,
                                    shbe_pkg::status_t st);
    shbe_pkg::out_t o;
    o.out_word    = w;
    o.valid_bytes = nb[3:0];
    o.last_word   = lw;
    o.status      = st;
    word_q.push_back(o);
  endfunction

  function automatic void clear_block();
    foreach (hist[i]) hist[i] = 0;
    blk_len = 0;
    phase   = shbe_pkg::FUNC_COUNT;
    bits[0] = '0;
    bits[1] = '0;
    fill    = 0;
  endfunction

  function automatic int pick_lightest();
    int unsigned best = 99999999;
    int found = -1;
    for (int i = 0; i < nodes && i < shbe_pkg::NODE_LIMIT; i++) begin
      if (!taken[i] && weight[i] != 0 && weight[i] < best) begin
        best  = weight[i];
        found = i;
      end
    end
    if (found >= 0) taken[found] = 1'b1;
    return found;
  endfunction

  function automatic shbe_pkg::status_t build_codes();
    longint unsigned code[shbe_pkg::NODE_LIMIT];
    int unsigned     len[shbe_pkg::NODE_LIMIT];
    int unsigned     peak = 0;
    int unsigned     root;
    int              a, b;
    foreach (hist[i]) if (hist[i] > peak) peak = hist[i];
    if (peak == 0) return shbe_pkg::ST_EMPTY;
    for (int i = 0; i < shbe_pkg::LEAF_COUNT; i++)
      weight[i] = int'((longint'(hist[i]) * 255 + peak - 1) / peak);
    foreach (taken[i]) taken[i] = 1'b0;
    nodes = shbe_pkg::LEAF_COUNT;
    while (nodes != shbe_pkg::NODE_LIMIT) begin
      a = pick_lightest();
      if (a < 0) break;
      b = pick_lightest();
      if (b < 0) begin
        if (a != nodes - 1) return shbe_pkg::ST_SINGLE;
        break;
      end
      kids[nodes][0] = a;
      kids[nodes][1] = b;
      weight[nodes]  = weight[a] + weight[b];
      nodes++;
    end
    foreach (code[i]) begin
      code[i] = 0;
      len[i]  = 0;
    end
    root = nodes - 1;
    for (int n = root; n >= shbe_pkg::LEAF_COUNT; n--) begin
      for (int k = 0; k < 2; k++) begin
        code[kids[n][k]] = (code[n] << 1) | k;
        len[kids[n][k]]  = len[n] + 1;
      end
    end
    for (int i = 0; i < shbe_pkg::LEAF_COUNT; i++)
      if (len[i] > shbe_pkg::MAX_CODE_BITS) return shbe_pkg::ST_CODE_LONG;
    for (int i = 0; i < shbe_pkg::LEAF_COUNT; i++) begin
      sym_code[i] = code[i][31:0];
      sym_len[i]  = len[i];
    end
    return shbe_pkg::ST_OK;
  endfunction

  function automatic void predict_words(shbe_pkg::in_t it);
    logic [7:0]  hdr[HDR_BYTES];
    logic [63:0] w;
    int unsigned nb, lcode, pos;
    int          k;
    shbe_pkg::status_t st;
    if (it.func != phase) begin
      push_word('0, 0, 1'b1, shbe_pkg::ST_ORDER);
      return;
    end
    if (it.func == shbe_pkg::FUNC_COUNT) begin
      if (blk_len >= (1 << shbe_pkg::LENGTH_BITS_DEF) - 1) begin
        clear_block();
        push_word('0, 0, 1'b1, shbe_pkg::ST_TOO_LONG);
        return;
      end
      hist[it.data_byte]++;
      blk_len++;
      if (!it.last) return;
      st = build_codes();
      if (st != shbe_pkg::ST_OK) begin
        clear_block();
        push_word('0, 0, 1'b1, st);
        return;
      end
      for (int i = 0; i < 4; i++) hdr[i] = blk_len[8*i +: 8];
      for (int i = 0; i < shbe_pkg::LEAF_COUNT; i++) hdr[4 + i] = weight[i][7:0];
      clear_block();
      phase = shbe_pkg::FUNC_ENCODE;
      for (int b = 0; b < HDR_BYTES; b += 8) begin
        w  = '0;
        nb = 0;
        for (int j = 0; j < 8 && b + j < HDR_BYTES; j++) begin
          w[8*j +: 8] = hdr[b + j];
          nb++;
        end
        push_word(w, nb, b + 8 >= HDR_BYTES, shbe_pkg::ST_OK);
      end
    end else begin
      lcode = sym_len[it.data_byte];
      if (lcode > shbe_pkg::MAX_CODE_BITS) lcode = shbe_pkg::MAX_CODE_BITS;
      k = 0;
      for (int j = 0; j < lcode; j++) begin
        pos = fill + j;
        bits[(pos >> 6) & 1][pos & 63] = bits[(pos >> 6) & 1][pos & 63]
                                         | sym_code[it.data_byte][lcode - 1 - j];
      end
      fill += lcode;
      if (fill >= 64) begin
        push_word(bits[0], 8, 1'b0, shbe_pkg::ST_OK);
        k++;
        bits[0] = bits[1];
        bits[1] = '0;
        fill -= 64;
      end
      if (!it.last) return;
      if (fill > 0) push_word(bits[0], (fill + 7) >> 3, 1'b1, shbe_pkg::ST_OK);
      else if (k > 0) word_q[$].last_word = 1'b1;
      else push_word('0, 0, 1'b1, shbe_pkg::ST_OK);
      clear_block();
    end
  endfunction

  // stimulus helpers
  function automatic void add_byte(logic f, logic [7:0] d, logic l);
    shbe_pkg::in_t it;
    it.func      = f;
    it.data_byte = d;
    it.last      = l;
    byte_q.push_back(it);
    items_made++;
  endfunction

  // one block: counting pass, then an encoding pass unless the tree build fails
  function automatic void add_block(logic [7:0] syms[$], int enc_mode);
    int unsigned first_val;
    bit          single = 1'b1;
    logic [7:0]  enc[$];
    blocks_made++;
    foreach (syms[i]) begin
      if ($urandom_range(0, 40) == 0)
        add_byte(shbe_pkg::FUNC_ENCODE, 8'($urandom), 1'($urandom));
      add_byte(shbe_pkg::FUNC_COUNT, syms[i], i == syms.size() - 1);
      if (syms[i] != syms[0]) single = 1'b0;
    end
    first_val = {24'd0, syms[0]};
    if (single && first_val != 255) return;
    case (enc_mode)
      0: enc = syms;
      1: begin
        for (int r = 0; r < 3; r++) foreach (syms[i]) enc.push_back(syms[i]);
      end
      default: begin
        for (int i = 0; i < $urandom_range(1, 14); i++)
          enc.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                    : syms[$urandom_range(0, syms.size() - 1)]);
      end
    endcase
    foreach (enc[i]) begin
      if ($urandom_range(0, 40) == 0)
        add_byte(shbe_pkg::FUNC_COUNT, 8'($urandom), 1'($urandom));
      add_byte(shbe_pkg::FUNC_ENCODE, enc[i], i == enc.size() - 1);
    end
  endfunction

  // sender: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      src_item  <= '0;
    end else begin
      if (src_valid && !src_stall) begin
        predict_words(src_item);
        void'(byte_q.pop_front());
      end
      if (!(src_valid && src_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          src_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          src_valid <= 1'b1;
          src_item  <= byte_q[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes mode every so often
  int stall_mode = 0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (rst) begin
      dst_stall <= 1'b0;
    end else begin
      if (dst_valid && !dst_stall) begin
        words_seen++;
        if (word_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: word %h bytes %0d last %0b status %0d",
                     dst_item.out_word, dst_item.valid_bytes, dst_item.last_word,
                     dst_item.status);
        end else begin
          if (dst_item.out_word !== word_q[0].out_word
              || dst_item.valid_bytes !== word_q[0].valid_bytes
              || dst_item.last_word !== word_q[0].last_word
              || dst_item.status !== word_q[0].status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp word %h bytes %0d last %0b status %0d, got %h %0d %0b %0d",
                       word_q[0].out_word, word_q[0].valid_bytes, word_q[0].last_word,
                       word_q[0].status, dst_item.out_word, dst_item.valid_bytes,
                       dst_item.last_word, dst_item.status);
          end
          void'(word_q.pop_front());
        end
      end
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run  = $urandom_range(20, 200);
      end
      stall_run--;
      case (stall_mode)
        0: dst_stall <= 1'b0;
        1: dst_stall <= ($urandom_range(0, 9) < 3);
        2: dst_stall <= ($urandom_range(0, 9) < 7);
        default: dst_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [7:0] syms[$];
    int         nsym, len;
    logic [7:0] alpha[$];
    rst = 1'b1;
    clear_block();
    foreach (weight[i]) begin
      weight[i]  = 0;
      taken[i]   = 1'b0;
      kids[i][0] = 0;
      kids[i][1] = 0;
    end
    foreach (sym_code[i]) begin
      sym_code[i] = '0;
      sym_len[i]  = 0;
    end
    nodes = shbe_pkg::LEAF_COUNT;

    // directed: wrong pass at start, lone 0xff, lone 0x00, skewed block, uncounted byte
    add_byte(shbe_pkg::FUNC_ENCODE, 8'hff, 1'b1);
    add_byte(shbe_pkg::FUNC_COUNT, 8'hff, 1'b1);
    add_byte(shbe_pkg::FUNC_COUNT, 8'h00, 1'b0);
    add_byte(shbe_pkg::FUNC_ENCODE, 8'hff, 1'b0);
    add_byte(shbe_pkg::FUNC_ENCODE, 8'hff, 1'b1);
    blocks_made += 2;
    add_byte(shbe_pkg::FUNC_COUNT, 8'h00, 1'b0);
    add_byte(shbe_pkg::FUNC_COUNT, 8'h00, 1'b1);
    syms = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'haa, 8'h55};
    add_block(syms, 0);
    add_byte(shbe_pkg::FUNC_COUNT, 8'h00, 1'b0);
    add_byte(shbe_pkg::FUNC_ENCODE, 8'h12, 1'b0);
    add_byte(shbe_pkg::FUNC_ENCODE, 8'h00, 1'b1);

    while (items_made < 250) begin
      alpha.delete();
      syms.delete();
      nsym = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < nsym; i++)
        alpha.push_back(($urandom_range(0, 7) == 0) ? 8'hff : 8'($urandom));
      len = $urandom_range(1, 14);
      if (len < nsym && nsym > 6) len = nsym;
      for (int i = 0; i < len; i++)
        syms.push_back(($urandom_range(0, 2) == 0) ? alpha[0]
                                                   : alpha[$urandom_range(0, nsym - 1)]);
      add_block(syms, $urandom_range(0, 2));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (byte_q.size() == 0 && !src_valid);
    wait (word_q.size() == 0);
    repeat (300) @(posedge clk);
    $display("sent %0d bytes in %0d blocks, checked %0d output transactions",
             items_made, blocks_made, words_seen);
    if (mismatches == 0 && word_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d transactions still expected", mismatches, word_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
